>>> rtl/core/rcc_pkg.sv
package rcc_pkg;

    localparam int REGION_SLOTS = 16;
    localparam int ADDR_W       = 64;
    localparam int CFG_W        = 5;
    localparam int IDX_IN_W     = 4;
    localparam int SLOT_W       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_RAW_W    = $clog2(REGION_SLOTS + 1);
    localparam int CNT_W        = (CNT_RAW_W > CFG_W) ? CNT_RAW_W : CFG_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_COVERED = 2'd0,
        STATUS_GAP     = 2'd1,
        STATUS_WRAP    = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } t_region;

endpackage

>>> rtl/core/range_coverage_checker_core.sv
// Write request: stored in the region RAM, no result.
// Zero-length or wrapping query: no scan; the result goes through S_DONE into the output register.
// Other queries: a cursor pass reads the active slots from the region RAM one per cycle,
// min(active_regions, 16) slots per pass; up to 17 passes before the result goes through S_DONE.
// One request in flight at a time; a finished result waits in the output register.
// Synchronous active-low reset: control idle, output empty, active_regions 0; table untouched.
module range_coverage_checker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [rcc_pkg::IDX_IN_W-1:0]  i_slot_index,
    input  logic [rcc_pkg::ADDR_W-1:0]    i_slot_start,
    input  logic [rcc_pkg::ADDR_W-1:0]    i_slot_end,
    input  logic [rcc_pkg::ADDR_W-1:0]    i_query_address,
    input  logic [rcc_pkg::ADDR_W-1:0]    i_query_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [rcc_pkg::CFG_W-1:0]     i_cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic                           r_out_valid;
    rcc_pkg::t_status               r_status;
    rcc_pkg::t_status               r_res;
    logic [rcc_pkg::CFG_W-1:0]      r_active;
    logic [rcc_pkg::CNT_W-1:0]      r_issue;
    logic [rcc_pkg::CNT_W-1:0]      r_pass;
    logic                           r_v1;
    logic                           r_hit;
    logic [rcc_pkg::ADDR_W-1:0]     r_clip;
    logic [rcc_pkg::ADDR_W-1:0]     r_cursor;
    logic [rcc_pkg::ADDR_W-1:0]     r_reach;
    logic [rcc_pkg::ADDR_W-1:0]     r_stop;

    logic                           w_accept;
    logic [rcc_pkg::ADDR_W:0]       w_sum;
    logic [rcc_pkg::CNT_W-1:0]      w_limit;
    logic                           w_rd_en;
    logic                           w_wr_en;
    logic                           w_pass_end;
    rcc_pkg::t_region               w_wr_data;
    rcc_pkg::t_region               w_rd_data;
    logic                           n_hit;
    logic [rcc_pkg::ADDR_W-1:0]     n_clip;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    assign w_sum = {1'b0, i_query_address} + {1'b0, i_query_length};

    assign w_limit = (rcc_pkg::CNT_W'(r_active) > rcc_pkg::CNT_W'(rcc_pkg::REGION_SLOTS)) ?
                     rcc_pkg::CNT_W'(rcc_pkg::REGION_SLOTS) : rcc_pkg::CNT_W'(r_active);

    assign w_wr_en = w_accept && (i_mode == rcc_pkg::MODE_WRITE) &&
                     (int'(i_slot_index) < rcc_pkg::REGION_SLOTS);
    assign w_wr_data.start_addr = i_slot_start;
    assign w_wr_data.end_addr   = i_slot_end;

    assign w_rd_en    = (r_state == S_SCAN) && (r_issue < w_limit);
    assign w_pass_end = (r_state == S_SCAN) && (r_issue == w_limit) && !r_v1 && !r_hit;

    always_comb begin
        n_hit  = r_v1 && (w_rd_data.start_addr <= r_cursor) && (r_cursor < w_rd_data.end_addr);
        n_clip = (w_rd_data.end_addr < r_stop) ? w_rd_data.end_addr : r_stop;
    end

    rcc_region_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (rcc_pkg::SLOT_W'(i_slot_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_issue[rcc_pkg::SLOT_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_v1        <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_v1  <= w_rd_en;
            r_hit <= n_hit;
            if (i_cfg_wr_en) begin
                r_active <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_mode == rcc_pkg::MODE_QUERY)) begin
                        if ((i_query_length == '0) || w_sum[rcc_pkg::ADDR_W]) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_pass_end) begin
                        if ((r_reach == r_cursor) || (r_reach == r_stop) ||
                            (r_pass == rcc_pkg::CNT_W'(rcc_pkg::REGION_SLOTS))) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_clip <= n_clip;
        end
        if (r_hit && (r_clip > r_reach)) begin
            r_reach <= r_clip;
        end
        if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_status <= r_res;
        end
        if (w_accept && (i_mode == rcc_pkg::MODE_QUERY)) begin
            r_stop   <= w_sum[rcc_pkg::ADDR_W-1:0];
            r_cursor <= i_query_address;
            r_reach  <= i_query_address;
            r_issue  <= '0;
            r_pass   <= '0;
            if (i_query_length == '0) begin
                r_res <= rcc_pkg::STATUS_COVERED;
            end else begin
                r_res <= rcc_pkg::STATUS_WRAP;
            end
        end
        if (w_rd_en) begin
            r_issue <= r_issue + 1'b1;
        end
        if (w_pass_end) begin
            r_cursor <= r_reach;
            if (r_reach == r_cursor) begin
                r_res <= rcc_pkg::STATUS_GAP;
            end else if (r_reach == r_stop) begin
                r_res <= rcc_pkg::STATUS_COVERED;
            end else if (r_pass == rcc_pkg::CNT_W'(rcc_pkg::REGION_SLOTS)) begin
                r_res <= rcc_pkg::STATUS_GAP;
            end else begin
                r_pass  <= r_pass + 1'b1;
                r_issue <= '0;
            end
        end
    end

endmodule

>>> rtl/core/rcc_region_ram.sv
module rcc_region_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [rcc_pkg::SLOT_W-1:0] i_wr_addr,
    input  rcc_pkg::t_region           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [rcc_pkg::SLOT_W-1:0] i_rd_addr,
    output rcc_pkg::t_region           o_rd_data
);

    rcc_pkg::t_region r_mem [rcc_pkg::REGION_SLOTS];
    rcc_pkg::t_region r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/rcc_checker.sv
module rcc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_mode,
    input logic [rcc_pkg::ADDR_W-1:0]    i_query_length,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status
);

    logic w_acc;

    assign w_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == rcc_pkg::STATUS_COVERED) ||
                        (o_status == rcc_pkg::STATUS_GAP) ||
                        (o_status == rcc_pkg::STATUS_WRAP))
        else $error("undefined status code");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_mode == rcc_pkg::MODE_WRITE) && !o_out_valid |=> !o_out_valid)
        else $error("write request produced a result");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_mode == rcc_pkg::MODE_QUERY) && (i_query_length == '0) && !o_out_valid
        |=> ##1 o_out_valid && (o_status == rcc_pkg::STATUS_COVERED))
        else $error("zero-length query not reported covered");

endmodule

bind range_coverage_checker_core rcc_checker u_rcc_checker (.*);
